@@ hw/rtl/bfc_pkg.sv @@
// bfc_pkg: shared types, widths and constants of the 3x3 box filter
// depends on nothing; imported by every module of the filter
`default_nettype none

package bfc_pkg;

  // largest image side the line buffers hold
  localparam int MAX_SIDE = 512;
  localparam int POS_W    = $clog2(MAX_SIDE);
  localparam int CHAN_W   = 16;
  localparam int SIDE_W   = 10;
  localparam int SUM_W    = CHAN_W + 4;
  localparam int CNT_W    = 4;

  // apb register map
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_IMAGE_SIDE = 2'd0;
  localparam logic [SIDE_W-1:0]  IMAGE_SIDE_RST  = 10'd512;

  // result queue between the window front and the divide back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // job codes, in raster order of the results one pixel releases
  localparam logic [1:0] JOB_UP_LEFT = 2'd0;
  localparam logic [1:0] JOB_UP      = 2'd1;
  localparam logic [1:0] JOB_LEFT    = 2'd2;
  localparam logic [1:0] JOB_HERE    = 2'd3;

  // reciprocals, exact floor for sums below 2**20 and counts up to nine
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = RCP_SHIFT + 1;
  localparam logic [RCP_W-1:0] RCP_1 = RCP_W'(1 << RCP_SHIFT);
  localparam logic [RCP_W-1:0] RCP_2 = RCP_W'((1 << RCP_SHIFT) / 2);
  localparam logic [RCP_W-1:0] RCP_3 = RCP_W'(((1 << RCP_SHIFT) + 2) / 3);
  localparam logic [RCP_W-1:0] RCP_4 = RCP_W'((1 << RCP_SHIFT) / 4);
  localparam logic [RCP_W-1:0] RCP_6 = RCP_W'(((1 << RCP_SHIFT) + 5) / 6);
  localparam logic [RCP_W-1:0] RCP_9 = RCP_W'(((1 << RCP_SHIFT) + 8) / 9);

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              run_last;
    logic              frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             run_last;
    logic             frame_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [RCP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] m;
    unique case (n)
      4'd2:    m = RCP_2;
      4'd3:    m = RCP_3;
      4'd4:    m = RCP_4;
      4'd6:    m = RCP_6;
      4'd9:    m = RCP_9;
      default: m = RCP_1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bfc_front.sv @@
// bfc_front: pixel intake, line buffers, window and per-result sums
// depends on bfc_pkg; feeds bfc_queue
`default_nettype none

module bfc_front import bfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic [POS_W-1:0] side_last,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  pix_in_t          pix,
  input  q_stat_t          q_stat,
  output logic             push,
  output job_t             job
);

  // line buffers, contents undefined until written
  pixel_t older_mem [MAX_SIDE];
  pixel_t prior_mem [MAX_SIDE];
  pixel_t older_rd;
  pixel_t prior_rd;

  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] col_count;
  pixel_t           wc [6];

  // held pixel and its pending results
  logic             s1_valid;
  pixel_t           s1_pix;
  logic [POS_W-1:0] s1_row;
  logic [POS_W-1:0] s1_col;
  logic [POS_W-1:0] s1_row_up;
  logic [POS_W-1:0] s1_col_left;
  logic             s1_rge1;
  logic             s1_rge2;
  logic             s1_cge1;
  logic             s1_cge2;
  logic [3:0]       s1_pend;

  logic       accept;
  logic       done;
  logic [1:0] jid;
  logic [3:0] pend_after;
  logic       last_row;
  logic       last_col;
  logic       upper;
  logic       left;
  logic [2:0] rowinc;
  logic [2:0] colinc;
  logic [1:0] nr;
  logic [1:0] nc;
  pixel_t     win [3][3];
  logic [SUM_W-1:0] col_r [3];
  logic [SUM_W-1:0] col_g [3];
  logic [SUM_W-1:0] col_b [3];
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;

  always_comb begin
    priority if (s1_pend[0]) begin
      jid = JOB_UP_LEFT;
    end else if (s1_pend[1]) begin
      jid = JOB_UP;
    end else if (s1_pend[2]) begin
      jid = JOB_LEFT;
    end else begin
      jid = JOB_HERE;
    end
  end

  assign pend_after = s1_pend & ~(4'b0001 << jid);
  assign push       = s1_valid && (s1_pend != 4'd0) && !q_stat.full;
  assign done       = s1_valid && ((s1_pend == 4'd0) || (push && pend_after == 4'd0));
  assign pix_ready  = !s1_valid || done;
  assign accept     = pix_valid && pix_ready;

  assign last_row = (row_count == side_last);
  assign last_col = (col_count == side_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_pend  <= 4'd0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_pend  <= {last_row && last_col,
                   last_row && (col_count != '0),
                   (row_count != '0) && last_col,
                   (row_count != '0) && (col_count != '0)};
    end else if (done) begin
      s1_valid <= 1'b0;
      s1_pend  <= 4'd0;
    end else if (push) begin
      s1_pend <= pend_after;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};
      s1_row      <= row_count;
      s1_col      <= col_count;
      s1_row_up   <= row_count - POS_W'(1);
      s1_col_left <= col_count - POS_W'(1);
      s1_rge1     <= (row_count != '0);
      s1_rge2     <= (row_count > POS_W'(1));
      s1_cge1     <= (col_count != '0);
      s1_cge2     <= (col_count > POS_W'(1));
      older_rd    <= older_mem[col_count];
      prior_rd    <= prior_mem[col_count];
    end
  end

  // roll the line buffers once the pixel has released all its results
  always_ff @(posedge clk) begin
    if (done) begin
      older_mem[s1_col] <= prior_rd;
      prior_mem[s1_col] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + POS_W'(1);
      end else begin
        col_count <= col_count + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < 6; i++) begin
        wc[i] <= '0;
      end
    end else if (done) begin
      for (int i = 0; i < 3; i++) begin
        wc[i] <= wc[3+i];
      end
      wc[3] <= older_rd;
      wc[4] <= prior_rd;
      wc[5] <= s1_pix;
    end
  end

  // window: column slot 2 and row slot 2 are the newest
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[0][r] = wc[r];
      win[1][r] = wc[3+r];
    end
    win[2][0] = older_rd;
    win[2][1] = prior_rd;
    win[2][2] = s1_pix;
  end

  // clipping of the neighbourhood for the selected result
  assign upper  = (jid == JOB_UP_LEFT) || (jid == JOB_UP);
  assign left   = (jid == JOB_UP_LEFT) || (jid == JOB_LEFT);
  assign rowinc = {1'b1, upper || s1_rge1, upper && s1_rge2};
  assign colinc = {1'b1, left || s1_cge1, left && s1_cge2};
  assign nr     = 2'd1 + 2'(rowinc[1]) + 2'(rowinc[0]);
  assign nc     = 2'd1 + 2'(colinc[1]) + 2'(colinc[0]);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_r[c] = '0;
      col_g[c] = '0;
      col_b[c] = '0;
      for (int r = 0; r < 3; r++) begin
        if (rowinc[r]) begin
          col_r[c] = col_r[c] + SUM_W'(win[c][r].red);
          col_g[c] = col_g[c] + SUM_W'(win[c][r].green);
          col_b[c] = col_b[c] + SUM_W'(win[c][r].blue);
        end
      end
    end
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int c = 0; c < 3; c++) begin
      if (colinc[c]) begin
        sum_r = sum_r + col_r[c];
        sum_g = sum_g + col_g[c];
        sum_b = sum_b + col_b[c];
      end
    end
  end

  always_comb begin
    job.sum_red   = sum_r;
    job.sum_green = sum_g;
    job.sum_blue  = sum_b;
    job.count     = CNT_W'(nr) * CNT_W'(nc);
    job.row       = upper ? s1_row_up : s1_row;
    job.col       = left ? s1_col_left : s1_col;
    job.run_last  = (pend_after == 4'd0);
    job.frame_end = (jid == JOB_HERE);
  end

endmodule

`default_nettype wire

@@ hw/rtl/bfc_queue.sv @@
// bfc_queue: short fifo of pending result jobs
// depends on bfc_pkg; sits between bfc_front and bfc_back
`default_nettype none

module bfc_queue import bfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  job_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (fill == QFILL_W'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + QFILL_W'(1);
        2'b01:   fill <= fill - QFILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bfc_back.sv @@
// bfc_back: divides window sums by the window count into the result register
// depends on bfc_pkg; drains bfc_queue
`default_nettype none

module bfc_back import bfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  job_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  output logic     res_valid,
  input  logic     res_ready,
  output pix_out_t res
);

  logic [RCP_W-1:0]       rcp;
  logic [SUM_W+RCP_W-1:0] prod_r;
  logic [SUM_W+RCP_W-1:0] prod_g;
  logic [SUM_W+RCP_W-1:0] prod_b;

  assign pop    = !q_stat.empty && (!res_valid || res_ready);
  assign rcp    = recip_of(head.count);
  assign prod_r = (SUM_W+RCP_W)'(head.sum_red)   * (SUM_W+RCP_W)'(rcp);
  assign prod_g = (SUM_W+RCP_W)'(head.sum_green) * (SUM_W+RCP_W)'(rcp);
  assign prod_b = (SUM_W+RCP_W)'(head.sum_blue)  * (SUM_W+RCP_W)'(rcp);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.out_red   <= prod_r[RCP_SHIFT +: CHAN_W];
      res.out_green <= prod_g[RCP_SHIFT +: CHAN_W];
      res.out_blue  <= prod_b[RCP_SHIFT +: CHAN_W];
      res.out_row   <= head.row;
      res.out_col   <= head.col;
      res.run_last  <= head.run_last;
      res.frame_end <= head.frame_end;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/box_filter_3x3_clamped.sv @@
// box_filter_3x3_clamped: streaming 3x3 mean filter with edge shrink, top level
// depends on bfc_pkg, bfc_front, bfc_queue, bfc_back
// throughput: one pixel and one result a cycle while the queue has room and results are
//   taken; a row-end pixel below the top row or a last-row pixel past column zero issues
//   two results and the frame's last pixel four
// reset: counters, window and queue cleared, image_side to 512; line buffers keep old contents
`default_nettype none

module box_filter_3x3_clamped import bfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // pixel request channel
  input  logic               pix_valid,
  output logic               pix_ready,
  input  pix_in_t            pix,
  // result request channel
  output logic               res_valid,
  input  logic               res_ready,
  output pix_out_t           res,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [SIDE_W-1:0] image_side;
  logic [POS_W-1:0]  side_last;
  logic              cfg_wr;
  logic              push;
  logic              pop;
  job_t              push_job;
  job_t              head;
  q_stat_t           q_stat;

  // apb: no wait states, a write lands on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_IMAGE_SIDE);
  assign prdata = (paddr == ADDR_IMAGE_SIDE) ? PDATA_W'(image_side) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side <= IMAGE_SIDE_RST;
    end else if (cfg_wr) begin
      image_side <= pwdata[SIDE_W-1:0];
    end
  end

  // last row and column index; a side of zero behaves as one,
  // a side beyond the line buffers behaves as the buffer length
  always_comb begin
    priority if (image_side == '0) begin
      side_last = '0;
    end else if ((SIDE_W+1)'(image_side) > (SIDE_W+1)'(MAX_SIDE)) begin
      side_last = POS_W'(MAX_SIDE - 1);
    end else begin
      side_last = POS_W'(image_side - SIDE_W'(1));
    end
  end

  // front: takes pixels, keeps the two previous rows and the window, and
  // turns each pixel into up to four sum-and-count jobs; a register write
  // restarts the frame at row zero, column zero
  bfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .side_last (side_last),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  // short queue so a stalled result port does not stall the pixel side at once
  bfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back: reciprocal multiply per channel straight into the result register
  bfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bfc_check.sv @@
// bfc_check: port-level checks of the box filter, bound to the top level
// depends on bfc_pkg and box_filter_3x3_clamped
`default_nettype none

module bfc_check import bfc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     res_valid,
  input logic     res_ready,
  input pix_out_t res,
  input logic     pready
);

  // nothing offered straight after reset
  a_idle_after_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // the frame's last pixel closes its run
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |-> res.run_last)
    else $error("frame end without run end");

  // the frame's last pixel lies on the diagonal, as the bottom-right corner does
  a_frame_end_corner: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |-> res.out_row == res.out_col)
    else $error("frame end off the diagonal corner");

  a_no_wait: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("apb wait state");

endmodule

bind box_filter_3x3_clamped bfc_check u_check (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for the 3x3 clamped box filter
// depends on bfc_pkg and box_filter_3x3_clamped; holds its own windowed-mean predictor,
// a pixel driver, a result monitor, an apb config sequence and a quiet-cycle watchdog
module tb_top import bfc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // random pixels after the directed cases
  localparam int RANDOM_PIXELS = 260;
  // cycles allowed for a pixel that releases no result to leave the pipeline
  localparam int SETTLE_CYCLES = 12;
  // cycles with no handshake of any kind before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               pix_valid = 1'b0;
  logic               pix_ready;
  pix_in_t            pix = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  pix_out_t           res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  box_filter_3x3_clamped u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the filter's line buffers, window and
  // raster position, plus the programmed side
  // ---------------------------------------------------------------------------
  pixel_t          older_line [MAX_SIDE];  // row r-2
  pixel_t          prior_line [MAX_SIDE];  // row r-1
  pixel_t          win_cols   [6];         // columns c-2 (0..2) and c-1 (3..5), rows r-2..r
  pixel_t          cur_win    [3][3];      // [column slot][row slot], slot 2 is current
  int              row_pos = 0;
  int              col_pos = 0;
  logic [SIDE_W-1:0] side_reg = IMAGE_SIDE_RST;

  pix_in_t  pixel_q[$];     // pixels waiting for the driver
  pix_out_t filtered_q[$];  // predicted filter outputs, oldest first

  int pushed_cnt = 0;   // pixels handed to the driver
  int taken_cnt  = 0;   // pixels accepted by the filter
  int mismatches = 0;
  int send_idle_pct  = 15;
  int recv_stall_pct = 47;
  int quiet_cycles   = 0;

  initial begin
    foreach (older_line[i]) begin
      older_line[i] = '0;
      prior_line[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;
  end

  // side as the filter uses it: zero acts as one, anything past the buffers as the maximum
  function automatic int used_side(logic [SIDE_W-1:0] s);
    if (s == '0) return 1;
    if (int'(s) > MAX_SIDE) return MAX_SIDE;
    return int'(s);
  endfunction

  // register write restarts the frame; line buffers keep what they hold
  function automatic void restart_frame(logic [SIDE_W-1:0] s);
    side_reg = s;
    row_pos  = 0;
    col_pos  = 0;
    foreach (win_cols[i]) win_cols[i] = '0;
  endfunction

  // truncating mean of the clipped 3x3 neighbourhood of (orow,ocol), taken from the
  // window as it stands when the pixel at (rr,cc) arrives
  function automatic pix_out_t window_mean(int orow, int ocol, int rr, int cc, int side,
                                           bit fend);
    int rlo, rhi, clo, chi, r, c, rs, cs, n;
    int unsigned sr, sg, sb;
    pix_out_t o;
    rlo = (orow > 0) ? orow - 1 : 0;
    rhi = (orow + 1 < side) ? orow + 1 : side - 1;
    clo = (ocol > 0) ? ocol - 1 : 0;
    chi = (ocol + 1 < side) ? ocol + 1 : side - 1;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (r = rlo; r <= rhi; r++) begin
      for (c = clo; c <= chi; c++) begin
        rs = r + 2 - rr;
        cs = c + 2 - cc;
        if (rs >= 0 && rs < 3 && cs >= 0 && cs < 3) begin
          sr += cur_win[cs][rs].red;
          sg += cur_win[cs][rs].green;
          sb += cur_win[cs][rs].blue;
          n++;
        end
      end
    end
    if (n == 0) n = 1;
    o.out_red   = CHAN_W'(sr / n);
    o.out_green = CHAN_W'(sg / n);
    o.out_blue  = CHAN_W'(sb / n);
    o.out_row   = POS_W'(orow);
    o.out_col   = POS_W'(ocol);
    o.run_last  = 1'b0;
    o.frame_end = fend;
    return o;
  endfunction

  // one accepted pixel: queue the outputs it completes, then roll window and line buffers
  function automatic void predict_means(pix_in_t p);
    int side, rr, cc, idx, i, k;
    bit last_row, last_col;
    pixel_t cur;
    pix_out_t outs[$];
    side = used_side(side_reg);
    rr = row_pos;
    cc = col_pos;
    if (rr >= side) rr = 0;
    if (cc >= side) cc = 0;
    idx = cc % MAX_SIDE;
    last_row = (rr == side - 1);
    last_col = (cc == side - 1);
    cur.red   = p.in_red;
    cur.green = p.in_green;
    cur.blue  = p.in_blue;
    for (i = 0; i < 3; i++) begin
      cur_win[0][i] = win_cols[i];
      cur_win[1][i] = win_cols[3 + i];
    end
    cur_win[2][0] = older_line[idx];
    cur_win[2][1] = prior_line[idx];
    cur_win[2][2] = cur;
    // released in raster order: up-left, up, left, here
    if (rr >= 1 && cc >= 1) outs.push_back(window_mean(rr - 1, cc - 1, rr, cc, side, 1'b0));
    if (rr >= 1 && last_col) outs.push_back(window_mean(rr - 1, cc, rr, cc, side, 1'b0));
    if (last_row && cc >= 1) outs.push_back(window_mean(rr, cc - 1, rr, cc, side, 1'b0));
    if (last_row && last_col) outs.push_back(window_mean(rr, cc, rr, cc, side, 1'b1));
    if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
    for (k = 0; k < outs.size(); k++) filtered_q.push_back(outs[k]);
    for (i = 0; i < 3; i++) begin
      win_cols[i]     = cur_win[1][i];
      win_cols[3 + i] = cur_win[2][i];
    end
    older_line[idx] = cur_win[2][1];
    prior_line[idx] = cur;
    cc++;
    if (cc >= side) begin
      cc = 0;
      rr++;
      if (rr >= side) rr = 0;
    end
    row_pos = rr;
    col_pos = cc;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: valid is raised independently of ready and held with a stable
  // payload until taken; gaps drawn from send_idle_pct
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && pix_ready) begin
        predict_means(pix);
        taken_cnt++;
      end
      if (!pix_valid || pix_ready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pix       <= pixel_q.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: each accepted request is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pix_out_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result request at row %0d col %0d", res.out_row, res.out_col);
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          if (res.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, res.out_red);
            mismatches++;
          end
          if (res.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, res.out_green);
            mismatches++;
          end
          if (res.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, res.out_blue);
            mismatches++;
          end
          if (res.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, res.out_row);
            mismatches++;
          end
          if (res.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, res.out_col);
            mismatches++;
          end
          if (res.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, res.run_last);
            mismatches++;
          end
          if (res.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, res.frame_end);
            mismatches++;
          end
        end
      end
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: any handshake on either channel or the apb port counts as progress
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((pix_valid && pix_ready) || (res_valid && res_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
    pix_in_t p;
    p.in_red   = r;
    p.in_green = g;
    p.in_blue  = b;
    pixel_q.push_back(p);
    pushed_cnt++;
  endtask

  // random channels, now and then pinned to either rail
  function automatic logic [CHAN_W-1:0] rand_chan();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
    return CHAN_W'($urandom_range(65535));
  endfunction

  task automatic queue_pixels(input int count);
    int i;
    for (i = 0; i < count; i++) push_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  // hold the sender until every pixel is taken and every predicted output has arrived,
  // then let a pixel that releases nothing clear the pipeline
  task automatic wait_drained();
    while (taken_cnt != pushed_cnt || filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb read of the side register, compared with what it should hold
  task automatic check_side_reg(input logic [SIDE_W-1:0] want);
    logic [PDATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_IMAGE_SIDE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PDATA_W'(want)) begin
      $error("image_side: expected %0d, got %0d", want, got);
      mismatches++;
    end
  endtask

  // apb write of the side register while idle; the predictor restarts on the write edge
  task automatic set_side(input logic [SIDE_W-1:0] s);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_IMAGE_SIDE;
    pwdata  <= PDATA_W'(s);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    restart_frame(s);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_side_reg(s);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int rnd_sent, pick, eff, cnt, split;
    bit first_phase;
    logic [SIDE_W-1:0] s;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset value of the side, then a stretch of the full-width top row, which completes nothing
    check_side_reg(IMAGE_SIDE_RST);
    queue_pixels(16);

    // single-pixel image: every pixel is its own mean, corner, last and frame end
    set_side(SIDE_W'(1));
    push_pixel('0, '0, '0);
    push_pixel('1, '1, '1);
    // side zero behaves as side one
    set_side('0);
    push_pixel('1, '0, '1);
    // 2x2 image: all four outputs are corners and come out of the last pixel
    set_side(SIDE_W'(2));
    push_pixel('0, '1, '0);
    push_pixel('1, '0, '1);
    push_pixel(16'h5555, 16'haaaa, 16'h8000);
    push_pixel(16'h7fff, 16'h0001, 16'hfffe);
    // 3x3 image on the rails: counts of nine, six and four over mostly full-scale pixels
    set_side(SIDE_W'(3));
    push_pixel('1, '1, '1);
    push_pixel('0, '0, '0);
    push_pixel('1, '1, '1);
    push_pixel('1, '1, '1);
    push_pixel('1, '1, '1);
    push_pixel('1, '1, '1);
    push_pixel('1, '0, '1);
    push_pixel('0, '1, '0);
    push_pixel('1, '1, '1);
    // frame wraps, then a rewrite in mid frame restarts the raster
    push_pixel('1, '1, '1);
    push_pixel(16'h1234, 16'h5678, 16'h9abc);
    push_pixel('0, '1, '0);
    push_pixel('1, '1, '1);
    push_pixel(16'hfff0, 16'h000f, 16'h0ff0);
    set_side(SIDE_W'(2));
    push_pixel('1, '1, '1);
    push_pixel('1, '1, '0);
    push_pixel('1, '0, '1);
    push_pixel('0, '1, '1);

    // side above the buffers is clipped to the maximum: a stretch of its top row
    set_side('1);
    queue_pixels(8);
    set_side(SIDE_W'(MAX_SIDE));
    queue_pixels(3);

    // random phases, mostly small images so frames complete often
    rnd_sent = 0;
    first_phase = 1'b1;
    while (rnd_sent < RANDOM_PIXELS) begin
      if (rnd_sent >= 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (rnd_sent >= RANDOM_PIXELS / 3) begin
        send_idle_pct  = 47;
        recv_stall_pct = 15;
      end
      pick = $urandom_range(99);
      if (pick < 8) s = SIDE_W'($urandom_range(1));
      else if (pick < 62) s = SIDE_W'($urandom_range(2, 6));
      else if (pick < 94) s = SIDE_W'($urandom_range(7, 11));
      else s = SIDE_W'($urandom_range(MAX_SIDE + 1, 1023));
      set_side(s);
      eff = used_side(s);
      if (eff == MAX_SIDE) begin
        cnt = $urandom_range(1, 12);
      end else begin
        cnt = eff * eff * ((eff <= 6) ? $urandom_range(1, 3) : 1) + $urandom_range(0, eff);
      end
      if (cnt > RANDOM_PIXELS - rnd_sent) cnt = RANDOM_PIXELS - rnd_sent;
      // sometimes stop the sender in mid frame until every output is back
      if (first_phase || $urandom_range(3) == 0) begin
        split = $urandom_range(1, cnt);
        queue_pixels(split);
        wait_drained();
        queue_pixels(cnt - split);
      end else begin
        queue_pixels(cnt);
      end
      first_phase = 1'b0;
      rnd_sent += cnt;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
